>>> design/pot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_pkg
// Shared codes and control bundles for the primitive overlap tester.
// ----------------------------------------------------------------------------
package pot_pkg;

    typedef logic [1:0] t_func;

    // Test kinds carried in the func field of a request.
    localparam t_func FUNC_SPHERE_SPHERE = 2'd0;
    localparam t_func FUNC_SPHERE_BOX    = 2'd1;
    localparam t_func FUNC_BOX_BOX       = 2'd2;
    localparam t_func FUNC_POINT_BOX     = 2'd3;

    // Control leaving the compare stage.
    typedef struct packed {
        t_func func;
        logic  box_hit;    // box against box, all three axes overlap
        logic  point_hit;  // point inside box, all three axes
    } t_cmp_ctl;

    // Control leaving the square stage.
    typedef struct packed {
        logic use_dist;    // hit comes from the squared distance compare
        logic flat_hit;    // hit for the interval tests
    } t_sq_ctl;

endpackage

>>> design/pot_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_front
// Stage one: unpack the coordinates, form per-axis differences against the
// B corners, evaluate the interval tests and the radius term.
// ----------------------------------------------------------------------------
module pot_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  pot_pkg::t_func                 i_func,
    input  logic [3*COORD_WIDTH-1:0]       i_vec_a0,
    input  logic [3*COORD_WIDTH-1:0]       i_vec_a1,
    input  logic [3*COORD_WIDTH-1:0]       i_vec_b0,
    input  logic [3*COORD_WIDTH-1:0]       i_vec_b1,
    input  logic [COORD_WIDTH-2:0]         i_radius_a,
    input  logic [COORD_WIDTH-2:0]         i_radius_b,
    output logic                           o_valid,
    output pot_pkg::t_cmp_ctl              o_ctl,
    output logic [2:0][COORD_WIDTH:0]      o_diff_lo,
    output logic [2:0][COORD_WIDTH:0]      o_diff_hi,
    output logic [COORD_WIDTH-1:0]         o_radius
);
    import pot_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic [2:0][DW-1:0]       n_diff_lo;
    logic [2:0][DW-1:0]       n_diff_hi;
    logic [2:0]               axis_box;
    logic [2:0]               axis_point;
    logic [COORD_WIDTH-1:0]   n_radius;
    t_cmp_ctl                 n_ctl;

    logic                     r_valid;
    t_cmp_ctl                 r_ctl;
    logic [2:0][DW-1:0]       r_diff_lo;
    logic [2:0][DW-1:0]       r_diff_hi;
    logic [COORD_WIDTH-1:0]   r_radius;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic signed [COORD_WIDTH-1:0] a0, a1, b0, b1;
        assign a0 = $signed(i_vec_a0[g*COORD_WIDTH +: COORD_WIDTH]);
        assign a1 = $signed(i_vec_a1[g*COORD_WIDTH +: COORD_WIDTH]);
        assign b0 = $signed(i_vec_b0[g*COORD_WIDTH +: COORD_WIDTH]);
        assign b1 = $signed(i_vec_b1[g*COORD_WIDTH +: COORD_WIDTH]);

        assign n_diff_lo[g] = {a0[COORD_WIDTH-1], a0} - {b0[COORD_WIDTH-1], b0};
        assign n_diff_hi[g] = {a0[COORD_WIDTH-1], a0} - {b1[COORD_WIDTH-1], b1};

        // Touching counts, so overlap fails only on strict separation.
        assign axis_box[g]   = !((a1 < b0) || (b1 < a0));
        // Inclusive bounds: a0 - b0 >= 0 and a0 - b1 <= 0.
        assign axis_point[g] = !n_diff_lo[g][DW-1] &&
                               (n_diff_hi[g][DW-1] || (n_diff_hi[g] == '0));
    end

    always_comb begin
        n_ctl.func      = i_func;
        n_ctl.box_hit   = &axis_box;
        n_ctl.point_hit = &axis_point;
        if (i_func == FUNC_SPHERE_SPHERE) begin
            n_radius = {1'b0, i_radius_a} + {1'b0, i_radius_b};
        end else begin
            n_radius = {1'b0, i_radius_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl     <= n_ctl;
            r_diff_lo <= n_diff_lo;
            r_diff_hi <= n_diff_hi;
            r_radius  <= n_radius;
        end
    end

    assign o_valid   = r_valid;
    assign o_ctl     = r_ctl;
    assign o_diff_lo = r_diff_lo;
    assign o_diff_hi = r_diff_hi;
    assign o_radius  = r_radius;

endmodule

>>> design/pot_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_square
// Stage two: pick the per-axis offset (centre difference or distance to the
// clamped point) and square it, square the radius term.
// ----------------------------------------------------------------------------
module pot_square #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  pot_pkg::t_cmp_ctl                i_ctl,
    input  logic [2:0][COORD_WIDTH:0]        i_diff_lo,
    input  logic [2:0][COORD_WIDTH:0]        i_diff_hi,
    input  logic [COORD_WIDTH-1:0]           i_radius,
    output logic                             o_valid,
    output pot_pkg::t_sq_ctl                 o_ctl,
    output logic [2:0][2*COORD_WIDTH:0]      o_sq,
    output logic [2*COORD_WIDTH-1:0]         o_radius_sq
);
    import pot_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int SQW = 2 * COORD_WIDTH + 1;

    logic [2:0][SQW-1:0]        n_sq;
    logic [2*COORD_WIDTH-1:0]   n_radius_sq;
    t_sq_ctl                    n_ctl;

    logic                       r_valid;
    t_sq_ctl                    r_ctl;
    logic [2:0][SQW-1:0]        r_sq;
    logic [2*COORD_WIDTH-1:0]   r_radius_sq;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic [DW-1:0]      d;
        logic signed [2*DW-1:0] prod;
        always_comb begin
            // Sphere-box: below min clamps to min, else above max to max.
            if (i_ctl.func == FUNC_SPHERE_SPHERE || i_diff_lo[g][DW-1]) begin
                d = i_diff_lo[g];
            end else if (!i_diff_hi[g][DW-1] && (i_diff_hi[g] != '0)) begin
                d = i_diff_hi[g];
            end else begin
                d = '0;
            end
        end
        assign prod    = $signed(d) * $signed(d);
        assign n_sq[g] = prod[SQW-1:0];
    end

    assign n_radius_sq = i_radius * i_radius;

    always_comb begin
        n_ctl.use_dist = (i_ctl.func == FUNC_SPHERE_SPHERE) ||
                         (i_ctl.func == FUNC_SPHERE_BOX);
        n_ctl.flat_hit = (i_ctl.func == FUNC_BOX_BOX) ? i_ctl.box_hit
                                                      : i_ctl.point_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl       <= n_ctl;
            r_sq        <= n_sq;
            r_radius_sq <= n_radius_sq;
        end
    end

    assign o_valid     = r_valid;
    assign o_ctl       = r_ctl;
    assign o_sq        = r_sq;
    assign o_radius_sq = r_radius_sq;

endmodule

>>> design/pot_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_reduce
// Stage three: sum the squared offsets, compare against the squared radius
// (or take the interval hit for the box tests) and hold the hit bit in the output register.
// ----------------------------------------------------------------------------
module pot_reduce #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  pot_pkg::t_sq_ctl               i_ctl,
    input  logic [2:0][2*COORD_WIDTH:0]    i_sq,
    input  logic [2*COORD_WIDTH-1:0]       i_radius_sq,
    output logic                           o_valid,
    output logic                           o_hit
);
    import pot_pkg::*;

    localparam int SQW  = 2 * COORD_WIDTH + 1;
    localparam int SUMW = SQW + 2;

    logic [SUMW-1:0] sum;
    logic            n_hit;
    logic            r_valid;
    logic            r_hit;

    assign sum = {2'b00, i_sq[0]} + {2'b00, i_sq[1]} + {2'b00, i_sq[2]};

    always_comb begin
        if (i_ctl.use_dist) begin
            n_hit = (sum <= {3'b000, i_radius_sq});
        end else begin
            n_hit = i_ctl.flat_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

>>> design/primitive_overlap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_overlap_test
// Pipelined overlap tester for spheres, axis-aligned boxes and points.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_func, i_vec_a0, i_vec_a1,
//                                            i_vec_b0, i_vec_b1,
//                                            i_radius_a, i_radius_b
//  result    out        o_valid / i_stall    o_hit
//
// One request per cycle is taken while o_stall is low; every request gives one
// result, passing through the three register stages (compare, square, reduce).
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and o_stall rises only when all three stages are full and
// the result is stalled. Reset clears the stage valid bits; the pipeline is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module primitive_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pot_pkg::t_func              i_func,
    input  logic [3*COORD_WIDTH-1:0]    i_vec_a0,
    input  logic [3*COORD_WIDTH-1:0]    i_vec_a1,
    input  logic [3*COORD_WIDTH-1:0]    i_vec_b0,
    input  logic [3*COORD_WIDTH-1:0]    i_vec_b1,
    input  logic [COORD_WIDTH-2:0]      i_radius_a,
    input  logic [COORD_WIDTH-2:0]      i_radius_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit
);
    import pot_pkg::*;

    // Stage valids and per-stage advance enables.
    logic                        v1, v2, v3;
    logic                        en1, en2, en3;

    t_cmp_ctl                    cmp_ctl;
    logic [2:0][COORD_WIDTH:0]   diff_lo;
    logic [2:0][COORD_WIDTH:0]   diff_hi;
    logic [COORD_WIDTH-1:0]      radius;

    t_sq_ctl                     sq_ctl;
    logic [2:0][2*COORD_WIDTH:0] sq;
    logic [2*COORD_WIDTH-1:0]    radius_sq;

    // Advance the output stage when it is empty or its result is taken;
    // advance earlier stages into any slot that frees up.
    assign en3     = !v3 || !i_stall;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign o_stall = !en1;

    // Compare stage: differences, interval tests, radius term.
    pot_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en1),
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_vec_a0   (i_vec_a0),
        .i_vec_a1   (i_vec_a1),
        .i_vec_b0   (i_vec_b0),
        .i_vec_b1   (i_vec_b1),
        .i_radius_a (i_radius_a),
        .i_radius_b (i_radius_b),
        .o_valid    (v1),
        .o_ctl      (cmp_ctl),
        .o_diff_lo  (diff_lo),
        .o_diff_hi  (diff_hi),
        .o_radius   (radius)
    );

    // Square stage: clamp select and the four multipliers.
    pot_square #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_square (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en2),
        .i_valid     (v1),
        .i_ctl       (cmp_ctl),
        .i_diff_lo   (diff_lo),
        .i_diff_hi   (diff_hi),
        .i_radius    (radius),
        .o_valid     (v2),
        .o_ctl       (sq_ctl),
        .o_sq        (sq),
        .o_radius_sq (radius_sq)
    );

    // Reduce stage: sum, compare, hold the result for the consumer.
    pot_reduce #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_reduce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en3),
        .i_valid     (v2),
        .i_ctl       (sq_ctl),
        .i_sq        (sq),
        .i_radius_sq (radius_sq),
        .o_valid     (v3),
        .o_hit       (o_hit)
    );

    assign o_valid = v3;

endmodule
